[rtl/reneq_pkg.sv]
// ----------------------------------------------------------------------------
// reneq_pkg: shared types and constants for the encoder and button event queue
// Event kinds, input modes, line levels and the layout of one stored event.
// ----------------------------------------------------------------------------
package reneq_pkg;

	// Field widths fixed by the interface.
	localparam int unsigned TimeW     = 32;
	localparam int unsigned KindW     = 2;
	localparam int unsigned HoldW     = 16;
	localparam int unsigned PendingW  = 4;
	localparam int unsigned DroppedW  = 2;
	localparam int unsigned InDataW   = 40;
	localparam int unsigned OutDataW  = 40;
	localparam int unsigned OutUserW  = 3;

	// Reset value of the hold time register.
	localparam logic [HoldW-1:0] HoldReset = 16'd50;

	// Line levels.
	localparam logic HIGH = 1'b1;
	localparam logic LOW  = 1'b0;

	// Input item selector.
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_POP    = 1'b1;

	// Event kinds.
	localparam logic [KindW-1:0] KIND_CW   = 2'd0;
	localparam logic [KindW-1:0] KIND_CCW  = 2'd1;
	localparam logic [KindW-1:0] KIND_DOWN = 2'd2;
	localparam logic [KindW-1:0] KIND_UP   = 2'd3;

	// One queue entry as held in the event memory.
	typedef struct packed {
		logic [TimeW-1:0] etime;
		logic [KindW-1:0] kind;
	} event_entry_t;

	localparam int unsigned EntryW = $bits(event_entry_t);

endpackage

[rtl/rotary_encoder_button_event_queue.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_button_event_queue: encoder and button decoder with event queue
// Turns pin samples into rotation and debounced button events held in a ring
// queue, and returns the oldest event on a pop.
// ----------------------------------------------------------------------------
// Each input beat is a pin sample or a pop and produces exactly one output
// beat. The block takes one beat per cycle unless the output stalls or a sample
// queues both a rotation and a button event; the input is then held off as the
// event memory has a single write port and the second entry is written in the
// next cycle. Pops read the memory through its registered read port. Output
// beats wait in an output register, so a stalled output only stops the input
// once the two-stage pipeline is full. The queue starts empty after reset with
// no clearing pass; all lines are assumed idle high.

module rotary_encoder_button_event_queue #(
	parameter int unsigned QUEUE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration: debounce hold time in ms.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,

	// Input beats.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] line_a, [1] line_b, [2] button_level, [34:3] now_ms
	input  logic        s_tuser,   // [0] mode

	// Output beats.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] event_time, [35:32] pending, [37:36] dropped
	output logic [2:0]  m_tuser    // [0] event_valid, [2:1] event_kind
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef logic [PW-1:0] ptr_t;
	typedef logic [CW-1:0] cnt_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (p == PW'(QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	// Control state.
	logic [reneq_pkg::HoldW-1:0] hold_q;
	logic                        prev_a_q;
	logic                        stable_btn_q;
	logic                        prev_raw_q;
	logic [reneq_pkg::TimeW-1:0] change_time_q;
	ptr_t                        rptr_q;
	ptr_t                        wptr_q;
	cnt_t                        fill_q;

	// Deferred second write of a sample that queued two events.
	logic                        pend_q;
	ptr_t                        pend_addr_q;
	reneq_pkg::event_entry_t     pend_data_q;

	// Pipeline stage 1 and the output register.
	logic                             valid_s1;
	logic                             hit_s1;
	logic [reneq_pkg::PendingW-1:0]   pending_s1;
	logic [reneq_pkg::DroppedW-1:0]   dropped_s1;
	logic                             out_valid_q;
	logic [reneq_pkg::OutDataW-1:0]   out_data_q;
	logic [reneq_pkg::OutUserW-1:0]   out_user_q;

	// Input fields.
	logic                        in_mode;
	logic                        in_a;
	logic                        in_b;
	logic                        in_btn;
	logic [reneq_pkg::TimeW-1:0] in_now;

	assign in_mode = s_tuser;
	assign in_a    = s_tdata[0];
	assign in_b    = s_tdata[1];
	assign in_btn  = s_tdata[2];
	assign in_now  = s_tdata[34:3];

	// Handshake.
	logic advance;
	logic accept;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !pend_q && (!valid_s1 || advance);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Sample decode: rotation edge and debounced button change.
	logic                        rot_ev;
	logic                        btn_ev;
	logic                        raw_chg;
	logic [reneq_pkg::TimeW-1:0] ct_next;
	logic [reneq_pkg::TimeW-1:0] held;
	reneq_pkg::event_entry_t     ev_rot;
	reneq_pkg::event_entry_t     ev_btn;

	always_comb begin
		rot_ev  = (prev_a_q == reneq_pkg::HIGH) && (in_a == reneq_pkg::LOW);
		raw_chg = in_btn != prev_raw_q;
		ct_next = raw_chg ? in_now : change_time_q;
		held    = in_now - ct_next;
		btn_ev  = (held >= {16'd0, hold_q}) && (in_btn != stable_btn_q);
		ev_rot.etime = in_now;
		ev_rot.kind  = in_b ? reneq_pkg::KIND_CW : reneq_pkg::KIND_CCW;
		ev_btn.etime = in_now;
		ev_btn.kind  = in_btn ? reneq_pkg::KIND_UP : reneq_pkg::KIND_DOWN;
	end

	// Queue update for the accepted beat.
	logic                           is_pop;
	logic                           is_sample;
	logic                           room1;
	logic                           room2;
	logic                           pop_hit;
	logic                           we_now;
	reneq_pkg::event_entry_t        wdata_now;
	logic                           defer;
	ptr_t                           wptr_next;
	ptr_t                           rptr_next;
	cnt_t                           fill_next;
	logic [reneq_pkg::DroppedW-1:0] dropped;

	always_comb begin
		is_pop    = accept && (in_mode == reneq_pkg::MODE_POP);
		is_sample = accept && (in_mode == reneq_pkg::MODE_SAMPLE);
		room1     = fill_q < CW'(QUEUE_DEPTH);
		room2     = fill_q < CW'(QUEUE_DEPTH - 1);
		pop_hit   = is_pop && (fill_q != '0);
		we_now    = 1'b0;
		wdata_now = ev_rot;
		defer     = 1'b0;
		wptr_next = wptr_q;
		rptr_next = rptr_q;
		fill_next = fill_q;
		dropped   = '0;
		if (pop_hit) begin
			rptr_next = ptr_inc(rptr_q);
			fill_next = fill_q - CW'(1);
		end
		if (is_sample) begin
			if (rot_ev && btn_ev) begin
				if (room2) begin
					we_now    = 1'b1;
					defer     = 1'b1;
					wptr_next = ptr_inc(ptr_inc(wptr_q));
					fill_next = fill_q + CW'(2);
				end else if (room1) begin
					we_now    = 1'b1;
					wptr_next = ptr_inc(wptr_q);
					fill_next = fill_q + CW'(1);
					dropped   = 2'd1;
				end else begin
					dropped   = 2'd2;
				end
			end else if (rot_ev || btn_ev) begin
				wdata_now = rot_ev ? ev_rot : ev_btn;
				if (room1) begin
					we_now    = 1'b1;
					wptr_next = ptr_inc(wptr_q);
					fill_next = fill_q + CW'(1);
				end else begin
					dropped   = 2'd1;
				end
			end
		end
	end

	// Event memory: the deferred write goes while the input is held off.
	logic                                  ram_we;
	ptr_t                                  ram_waddr;
	logic [reneq_pkg::EntryW-1:0]          ram_wdata;
	reneq_pkg::event_entry_t               ram_rdata;

	assign ram_we    = we_now || pend_q;
	assign ram_waddr = pend_q ? pend_addr_q : wptr_q;
	assign ram_wdata = pend_q ? pend_data_q : wdata_now;

	reneq_ram #(
		.WIDTH(reneq_pkg::EntryW),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop_hit),
		.raddr(rptr_q),
		.rdata(ram_rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= reneq_pkg::HoldReset;
		end else if (cfg_valid && cfg_ready) begin
			hold_q <= cfg_data;
		end
	end

	// Decoder and queue control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q      <= reneq_pkg::HIGH;
			stable_btn_q  <= reneq_pkg::HIGH;
			prev_raw_q    <= reneq_pkg::HIGH;
			change_time_q <= '0;
			rptr_q        <= '0;
			wptr_q        <= '0;
			fill_q        <= '0;
			pend_q        <= 1'b0;
		end else begin
			pend_q <= defer;
			if (is_sample) begin
				prev_a_q      <= in_a;
				prev_raw_q    <= in_btn;
				change_time_q <= ct_next;
				if (btn_ev) begin
					stable_btn_q <= in_btn;
				end
			end
			if (accept) begin
				rptr_q <= rptr_next;
				wptr_q <= wptr_next;
				fill_q <= fill_next;
			end
		end
	end

	// Second entry of a double push, written in the next cycle.
	always_ff @(posedge clk) begin
		if (defer) begin
			pend_addr_q <= ptr_inc(wptr_q);
			pend_data_q <= ev_btn;
		end
	end

	// Stage 1 waits for the memory read.
	logic [CW+reneq_pkg::PendingW-1:0] fill_ext;

	assign fill_ext = {{reneq_pkg::PendingW{1'b0}}, fill_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= pop_hit;
			pending_s1 <= fill_ext[reneq_pkg::PendingW-1:0];
			dropped_s1 <= dropped;
		end
	end

	// Output register; an empty pop or a sample reports a zero event.
	reneq_pkg::event_entry_t ev_out;

	assign ev_out = hit_s1 ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q <= {2'b00, dropped_s1, pending_s1, ev_out.etime};
			out_user_q <= {ev_out.kind, hit_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// Checks.
	a_pend_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !s_tready)
		else $error("input taken while a deferred write is pending");

	a_pend_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("deferred write lasted more than one cycle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[37:36] == 2'd0))
		else $error("popped event reports dropped events");

endmodule

[rtl/reneq_ram.sv]
// ----------------------------------------------------------------------------
// reneq_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module reneq_ram #(
	parameter int unsigned WIDTH = 34,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[dv/rotary_encoder_button_event_queue_test.sv]
// ----------------------------------------------------------------------------
// rotary_encoder_button_event_queue_test: self-checking bench for the event queue
// Drives pin samples and pops over the input stream. A behavioral copy of the
// decoder and ring queue predicts every output beat, which is then checked field
// by field. Random stalls are applied on both streams and the hold time register
// is swept between phases.
// ----------------------------------------------------------------------------
module rotary_encoder_button_event_queue_test;

	localparam int unsigned QDepth     = 8;
	localparam int unsigned StallLimit = 5000;
	localparam int unsigned MaxReports = 10;

	// One expected output beat.
	typedef struct packed {
		logic                           ev_valid;
		logic [reneq_pkg::KindW-1:0]    kind;
		logic [reneq_pkg::TimeW-1:0]    etime;
		logic [reneq_pkg::PendingW-1:0] pending;
		logic [reneq_pkg::DroppedW-1:0] dropped;
	} queue_report_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [reneq_pkg::HoldW-1:0]    cfg_data  = '0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [reneq_pkg::InDataW-1:0]  s_tdata   = '0;
	logic                           s_tuser   = reneq_pkg::MODE_SAMPLE;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [reneq_pkg::OutDataW-1:0] m_tdata;
	logic [reneq_pkg::OutUserW-1:0] m_tuser;

	rotary_encoder_button_event_queue #(
		.QUEUE_DEPTH(QDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Clock with a period of 12 units.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Behavioral copy of the decoder state and the event ring.
	logic                        pin_prev_a    = reneq_pkg::HIGH;
	logic                        btn_stable    = reneq_pkg::HIGH;
	logic                        btn_raw_last  = reneq_pkg::HIGH;
	logic [reneq_pkg::TimeW-1:0] btn_change_ms = '0;
	logic [reneq_pkg::HoldW-1:0] hold_ms       = reneq_pkg::HoldReset;
	reneq_pkg::event_entry_t     ring_store [QDepth];
	int unsigned                 ring_rd       = 0;
	int unsigned                 ring_wr       = 0;
	int unsigned                 ring_fill     = 0;

	queue_report_t predicted_beats [$];
	int unsigned   mismatch_count = 0;

	// Stream control shared by the sender, the receiver and the tests.
	bit tx_quiet    = 1'b0;
	bit rx_quiet    = 1'b0;
	int rx_hold_left = 0;

	// Generator state for well-formed pin sequences.
	int unsigned                 seq_phase  = 0;
	logic                        seq_btn    = reneq_pkg::HIGH;
	int unsigned                 seq_bounce = 0;
	logic [reneq_pkg::TimeW-1:0] seq_now    = '0;

	// Queue one event in the ring; returns 1 when it had to be dropped.
	function automatic logic [reneq_pkg::DroppedW-1:0] ring_push(
			logic [reneq_pkg::KindW-1:0] kind, logic [reneq_pkg::TimeW-1:0] stamp);
		if (ring_fill >= QDepth) begin
			return 2'd1;
		end
		ring_store[ring_wr].kind  = kind;
		ring_store[ring_wr].etime = stamp;
		ring_wr = (ring_wr + 1) % QDepth;
		ring_fill++;
		return 2'd0;
	endfunction

	// Work out the output beat caused by one accepted input beat.
	function automatic queue_report_t predict_beat(logic mode, logic a, logic b, logic btn,
			logic [reneq_pkg::TimeW-1:0] now);
		queue_report_t               res;
		logic [reneq_pkg::TimeW-1:0] held;
		res = '0;
		if (mode == reneq_pkg::MODE_POP) begin
			if (ring_fill != 0) begin
				res.ev_valid = 1'b1;
				res.kind     = ring_store[ring_rd].kind;
				res.etime    = ring_store[ring_rd].etime;
				ring_rd = (ring_rd + 1) % QDepth;
				ring_fill--;
			end
		end else begin
			// Rotation comes first: a falling edge of A, direction from B.
			if (pin_prev_a == reneq_pkg::HIGH && a == reneq_pkg::LOW) begin
				res.dropped += ring_push(b ? reneq_pkg::KIND_CW : reneq_pkg::KIND_CCW, now);
			end
			pin_prev_a = a;
			// Button debounce with a wrapping time difference.
			if (btn != btn_raw_last) begin
				btn_change_ms = now;
				btn_raw_last  = btn;
			end
			held = now - btn_change_ms;
			if (held >= reneq_pkg::TimeW'(hold_ms) && btn != btn_stable) begin
				btn_stable = btn;
				res.dropped += ring_push(btn ? reneq_pkg::KIND_UP : reneq_pkg::KIND_DOWN, now);
			end
		end
		res.pending = reneq_pkg::PendingW'(ring_fill);
		return res;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one beat, wait for the handshake, then record its prediction.
	task automatic send_beat(logic mode, logic a, logic b, logic btn,
			logic [reneq_pkg::TimeW-1:0] now);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(reneq_pkg::InDataW - reneq_pkg::TimeW - 3){1'b0}}, now, btn, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted_beats.push_back(predict_beat(mode, a, b, btn, now));
		gap = tx_quiet ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted beat has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (predicted_beats.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the hold time register while the block is idle.
	task automatic write_hold(logic [reneq_pkg::HoldW-1:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		hold_ms = value;
		cfg_valid <= 1'b0;
	endtask

	// Mixed traffic: mostly well-formed encoder and button motion, some pops
	// with junk pin fields, and some fully random samples.
	task automatic run_mixed(int unsigned count, int unsigned step_max);
		int unsigned r;
		logic        raw;
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				send_beat(reneq_pkg::MODE_POP, 1'($urandom), 1'($urandom), 1'($urandom),
					$urandom);
			end else if (r < 36) begin
				send_beat(reneq_pkg::MODE_SAMPLE, 1'($urandom), 1'($urandom), 1'($urandom),
					$urandom);
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					seq_now += $urandom_range(0, 2 * int'(hold_ms) + 2);
				end else begin
					seq_now += $urandom_range(0, step_max);
				end
				r = $urandom_range(0, 9);
				if (r >= 7) seq_phase = (seq_phase + 1) % 4;
				else if (r >= 4) seq_phase = (seq_phase + 3) % 4;
				if (seq_bounce == 0 && $urandom_range(0, 19) == 0) begin
					seq_btn    = ~seq_btn;
					seq_bounce = $urandom_range(0, 4);
				end
				if (seq_bounce > 0) begin
					raw = 1'($urandom);
					seq_bounce--;
				end else begin
					raw = seq_btn;
				end
				send_beat(reneq_pkg::MODE_SAMPLE, logic'(seq_phase == 0 || seq_phase == 3),
					logic'(seq_phase == 0 || seq_phase == 1), raw, seq_now);
			end
		end
	endtask

	// Rotation both ways and a debounced press with the reset hold time.
	task automatic test_reset_hold();
		logic [reneq_pkg::TimeW-1:0] t0;
		t0 = 32'd1000;
		send_beat(reneq_pkg::MODE_POP, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::LOW,
			32'hFFFF_FFFF);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::HIGH,
			t0);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, reneq_pkg::HIGH, reneq_pkg::HIGH,
			t0 + 1);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::LOW, reneq_pkg::HIGH,
			t0 + 2);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::HIGH,
			t0 + 3);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::LOW,
			t0 + 10);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::LOW,
			t0 + 59);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::LOW,
			t0 + 60);
		repeat (4) send_beat(reneq_pkg::MODE_POP, reneq_pkg::LOW, reneq_pkg::LOW,
			reneq_pkg::LOW, '0);
	endtask

	// Zero hold time across the time wrap: fill the ring and overflow it.
	task automatic test_zero_hold_overflow();
		logic [reneq_pkg::TimeW-1:0] t;
		write_hold('0);
		t = 32'hFFFF_FFFA;
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::HIGH, t);
		for (int k = 0; k < 4; k++) begin
			// Each falling edge also presses the button, the next sample releases it.
			t = t + 32'd1;
			send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::LOW, logic'(k[0]), reneq_pkg::LOW, t);
			t = t + 32'd1;
			send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::LOW, reneq_pkg::HIGH,
				t);
		end
		repeat (QDepth + 1) send_beat(reneq_pkg::MODE_POP, reneq_pkg::HIGH, reneq_pkg::HIGH,
			reneq_pkg::HIGH, '1);
	endtask

	// Largest hold time, with the hold window spanning the time wrap.
	task automatic test_max_hold();
		logic [reneq_pkg::TimeW-1:0] t;
		write_hold('1);
		t = 32'hFFFF_8000;
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::LOW, t);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::LOW,
			t + 32'd65534);
		send_beat(reneq_pkg::MODE_SAMPLE, reneq_pkg::HIGH, reneq_pkg::HIGH, reneq_pkg::LOW,
			t + 32'd65535);
		send_beat(reneq_pkg::MODE_POP, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::LOW, '0);
		send_beat(reneq_pkg::MODE_POP, reneq_pkg::LOW, reneq_pkg::LOW, reneq_pkg::LOW, '0);
	endtask

	// One random phase under a given hold time.
	task automatic test_random_phase(logic [reneq_pkg::HoldW-1:0] hold, int unsigned count,
			int unsigned step_max);
		write_hold(hold);
		seq_now = $urandom;
		run_mixed(count, step_max);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_output_stall();
		wait_drained();
		tx_quiet     = 1'b1;
		rx_hold_left = 400;
		run_mixed(40, 10);
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// The sender pauses mid-stream until every result has come back.
	task automatic test_sender_pause();
		run_mixed(60, 10);
		wait_drained();
		run_mixed(60, 10);
	endtask

	// A stretch with no idling on either side.
	task automatic test_full_rate();
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		run_mixed(150, 8);
		wait_drained();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Output receiver: random stalls, plus long hold-offs on request.
	initial begin : rx_proc
		int idle_left;
		idle_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_tready <= 1'b0;
			end else begin
				idle_left = rx_quiet ? 0 : gap_len();
				if (idle_left > 0) begin
					idle_left--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Compare each output beat with the oldest prediction.
	always @(posedge clk) begin : out_check
		queue_report_t got;
		queue_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.ev_valid = m_tuser[0];
			got.kind     = m_tuser[2:1];
			got.etime    = m_tdata[31:0];
			got.pending  = m_tdata[35:32];
			got.dropped  = m_tdata[37:36];
			if (predicted_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxReports) begin
					$display("unexpected beat: valid %0d kind %0d time %h pending %0d dropped %0d",
						got.ev_valid, got.kind, got.etime, got.pending, got.dropped);
				end
			end else begin
				want = predicted_beats.pop_front();
				if (got.ev_valid !== want.ev_valid || got.kind !== want.kind ||
						got.etime !== want.etime || got.pending !== want.pending ||
						got.dropped !== want.dropped) begin
					mismatch_count++;
					if (mismatch_count <= MaxReports) begin
						$display("mismatch: want valid %0d kind %0d time %h pending %0d dropped %0d",
							want.ev_valid, want.kind, want.etime, want.pending, want.dropped);
						$display("          got  valid %0d kind %0d time %h pending %0d dropped %0d",
							got.ev_valid, got.kind, got.etime, got.pending, got.dropped);
					end
				end
			end
		end
	end

	// Watchdog: too many cycles with no beat moving on any channel.
	always @(posedge clk) begin : watchdog
		int unsigned quiet_cycles;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_hold();
		test_zero_hold_overflow();
		test_max_hold();
		test_random_phase(16'd50, 120, 20);
		test_random_phase(16'd0, 120, 3);
		test_random_phase(16'd1, 120, 2);
		test_random_phase(16'hFFFF, 120, 5000);
		test_random_phase(16'h5555, 80, 3000);
		test_random_phase(16'hAAAA, 80, 5000);
		test_random_phase(16'd7, 120, 4);
		test_output_stall();
		test_sender_pause();
		test_random_phase(16'($urandom_range(0, 200)), 100, 30);
		test_full_rate();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_beats.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
